[rtl/assert_macros.svh]
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, skipped while reset is asserted
`define MPSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define MPSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mpsd_pkg.sv]
// ----------------------------------------------------------------------------
// mpsd_pkg
// shared constants and types of the min pairwise squared distance unit
// ----------------------------------------------------------------------------
`default_nettype none

package mpsd_pkg;

  localparam int MAX_POINTS = 32;
  localparam int COORD_BITS = 5;
  localparam int NUM_DIMS   = 4;
  // lane count is a power of two of at least two
  localparam int NUM_LANES  = 4;
  localparam int LANE_BITS  = $clog2(NUM_LANES);

  // the store is split into one bank per lane, point k sits in bank k mod lanes
  localparam int ROWS    = (MAX_POINTS + NUM_LANES - 1) / NUM_LANES;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int EXT_W   = ROW_W + LANE_BITS + 1;
  localparam int POINT_W = NUM_DIMS * COORD_BITS;

  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 2;
  localparam int MIN_W  = 14;
  localparam int CMP_W  = (DIST_W > MIN_W) ? DIST_W : MIN_W;

  localparam logic [MIN_W-1:0] NO_PAIR_SCORE = MIN_W'(10000);

  // ram read, lane register, merge register
  localparam int DRAIN_CYCLES = 3;
  localparam int DRAIN_W      = 2;

  typedef logic [NUM_DIMS-1:0][COORD_BITS-1:0] point_t;

  typedef struct packed {
    logic             valid;
    logic [CMP_W-1:0] dist_val;
  } dist_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[rtl/mpsd_ram.sv]
// ----------------------------------------------------------------------------
// mpsd_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mpsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/mpsd_lane.sv]
// ----------------------------------------------------------------------------
// mpsd_lane
// squared distance between the new point and one stored point
// ----------------------------------------------------------------------------
`default_nettype none

module mpsd_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mpsd_pkg::point_t   rd_point,
  input  wire logic               rd_valid,
  input  wire mpsd_pkg::point_t   new_point,
  output mpsd_pkg::dist_res_t     res
);

  logic                        valid_r;
  logic [mpsd_pkg::CMP_W-1:0]  dist_r;
  logic [mpsd_pkg::DIST_W-1:0] sum;

  always_comb begin
    logic [mpsd_pkg::COORD_BITS-1:0] diff;
    logic [mpsd_pkg::SQ_W-1:0]       sq;
    sum = '0;
    for (int d = 0; d < mpsd_pkg::NUM_DIMS; d++) begin
      diff = (rd_point[d] >= new_point[d]) ? (rd_point[d] - new_point[d])
                                            : (new_point[d] - rd_point[d]);
      sq   = mpsd_pkg::SQ_W'(diff) * mpsd_pkg::SQ_W'(diff);
      sum  = sum + mpsd_pkg::DIST_W'(sq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= mpsd_pkg::CMP_W'(sum);
  end

  assign res.valid    = valid_r;
  assign res.dist_val = dist_r;

endmodule

`default_nettype wire

[rtl/mpsd_merge.sv]
// ----------------------------------------------------------------------------
// mpsd_merge
// smallest distance over the lanes of one row
// ----------------------------------------------------------------------------
`default_nettype none

module mpsd_merge (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mpsd_pkg::dist_res_t lane_res [mpsd_pkg::NUM_LANES],
  output mpsd_pkg::dist_res_t      res
);

  logic                       valid_r;
  logic [mpsd_pkg::CMP_W-1:0] dist_r;
  logic                       any_valid;
  logic [mpsd_pkg::CMP_W-1:0] best;

  always_comb begin
    logic [mpsd_pkg::CMP_W-1:0] cand;
    any_valid = 1'b0;
    best      = mpsd_pkg::CMP_W'(mpsd_pkg::NO_PAIR_SCORE);
    for (int l = 0; l < mpsd_pkg::NUM_LANES; l++) begin
      cand      = lane_res[l].valid ? lane_res[l].dist_val
                                    : mpsd_pkg::CMP_W'(mpsd_pkg::NO_PAIR_SCORE);
      any_valid = any_valid | lane_res[l].valid;
      if (cand < best) begin
        best = cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= any_valid;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= best;
  end

  assign res.valid    = valid_r;
  assign res.dist_val = dist_r;

endmodule

`default_nettype wire

[rtl/min_pairwise_squared_distance_unit.sv]
// ----------------------------------------------------------------------------
// min_pairwise_squared_distance_unit
// busy stays high for a point while the stored points are scanned one row per
//   cycle from each of the four lane banks, while the ram read, lane register and
//   merge register drain, and for the finish step; a point of an empty or full
//   store goes straight to the finish step
// a new point is taken only while busy is low; the result strobe comes in the
//   cycle after the finish step of the last point, and the receiver cannot stall it
// reset (synchronous, active low) empties the set, resets the minimum to the no-pair
//   score and clears the overflow flag; the point banks keep their contents and are not swept
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module min_pairwise_squared_distance_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [mpsd_pkg::COORD_BITS-1:0] in_coord_0,
  input  wire logic [mpsd_pkg::COORD_BITS-1:0] in_coord_1,
  input  wire logic [mpsd_pkg::COORD_BITS-1:0] in_coord_2,
  input  wire logic [mpsd_pkg::COORD_BITS-1:0] in_coord_3,
  input  wire logic                            in_last_point,
  // result channel
  output logic                                 out_valid,
  output logic [mpsd_pkg::MIN_W-1:0]           out_min_sq_distance,
  output logic                                 out_overflow
);

  localparam int L = mpsd_pkg::NUM_LANES;

  // control state
  mpsd_pkg::state_t                state_r, state_nxt;
  logic [mpsd_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [mpsd_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [mpsd_pkg::DRAIN_W-1:0]    drain_r, drain_nxt;
  logic [mpsd_pkg::MIN_W-1:0]      min_r, min_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [L-1:0]                    vld_d1_r, vld_d1_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // payload held for the transaction in flight
  mpsd_pkg::point_t                point_r, point_nxt;
  logic                            last_r, last_nxt;
  logic [mpsd_pkg::MIN_W-1:0]      out_min_r, out_min_nxt;
  logic                            out_ovf_r, out_ovf_nxt;

  // lane side
  logic [L-1:0]                    lane_issue;
  logic [L-1:0]                    bank_we;
  logic [mpsd_pkg::ROW_W-1:0]      wr_row;
  logic [mpsd_pkg::CNT_W-1:0]      wr_shift;
  logic [mpsd_pkg::ROW_W:0]        row_inc;
  logic [mpsd_pkg::EXT_W-1:0]      next_base;
  logic [mpsd_pkg::EXT_W-1:0]      count_ext;
  logic                            store_ok;
  logic                            ovf_now;
  mpsd_pkg::point_t                rd_point [L];
  mpsd_pkg::dist_res_t             lane_res [L];
  mpsd_pkg::dist_res_t             mrg_res;

  // bank and row of the next free slot
  assign wr_shift  = count_r >> mpsd_pkg::LANE_BITS;
  assign wr_row    = wr_shift[mpsd_pkg::ROW_W-1:0];
  assign count_ext = mpsd_pkg::EXT_W'(count_r);
  // first point index of the row after the one being read
  assign row_inc   = {1'b0, row_r} + 1'b1;
  assign next_base = {row_inc, {mpsd_pkg::LANE_BITS{1'b0}}};
  assign store_ok  = count_r < mpsd_pkg::CNT_W'(mpsd_pkg::MAX_POINTS);
  assign ovf_now   = ovf_r | ~store_ok;

  for (genvar l = 0; l < L; l++) begin : g_lane
    logic [mpsd_pkg::EXT_W-1:0] lane_idx;

    // only slots below the fill count hold points of this set
    assign lane_idx      = {1'b0, row_r, mpsd_pkg::LANE_BITS'(l)};
    assign lane_issue[l] = (state_r == mpsd_pkg::ST_SCAN) && (lane_idx < count_ext);
    assign bank_we[l]    = (state_r == mpsd_pkg::ST_FINISH) && store_ok &&
                           (count_r[mpsd_pkg::LANE_BITS-1:0] == mpsd_pkg::LANE_BITS'(l));

    mpsd_ram #(
      .WIDTH (mpsd_pkg::POINT_W),
      .DEPTH (mpsd_pkg::ROWS)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[l]),
      .waddr (wr_row),
      .wdata (point_r),
      .raddr (row_r),
      .rdata (rd_point[l])
    );

    mpsd_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .rd_point  (rd_point[l]),
      .rd_valid  (vld_d1_r[l]),
      .new_point (point_r),
      .res       (lane_res[l])
    );
  end

  mpsd_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .lane_res (lane_res),
    .res      (mrg_res)
  );

  // next state and control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    row_nxt       = row_r;
    drain_nxt     = drain_r;
    min_nxt       = min_r;
    ovf_nxt       = ovf_r;
    vld_d1_nxt    = lane_issue;
    out_valid_nxt = 1'b0;
    point_nxt     = point_r;
    last_nxt      = last_r;
    out_min_nxt   = out_min_r;
    out_ovf_nxt   = out_ovf_r;

    // fold in the best distance of a row as it leaves the merge stage
    if (mrg_res.valid && (mrg_res.dist_val < mpsd_pkg::CMP_W'(min_r))) begin
      min_nxt = mrg_res.dist_val[mpsd_pkg::MIN_W-1:0];
    end

    unique case (state_r)
      mpsd_pkg::ST_IDLE: begin
        if (start) begin
          point_nxt = {in_coord_3, in_coord_2, in_coord_1, in_coord_0};
          last_nxt  = in_last_point;
          row_nxt   = '0;
          // nothing to compare against, or a point that will be dropped
          if ((count_r == '0) || !store_ok) begin
            state_nxt = mpsd_pkg::ST_FINISH;
          end else begin
            state_nxt = mpsd_pkg::ST_SCAN;
          end
        end
      end
      mpsd_pkg::ST_SCAN: begin
        row_nxt = row_r + 1'b1;
        if (next_base >= count_ext) begin
          drain_nxt = '0;
          state_nxt = mpsd_pkg::ST_DRAIN;
        end
      end
      mpsd_pkg::ST_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == mpsd_pkg::DRAIN_W'(mpsd_pkg::DRAIN_CYCLES - 1)) begin
          state_nxt = mpsd_pkg::ST_FINISH;
        end
      end
      mpsd_pkg::ST_FINISH: begin
        state_nxt = mpsd_pkg::ST_IDLE;
        if (store_ok) begin
          count_nxt = count_r + 1'b1;
        end
        ovf_nxt = ovf_now;
        if (last_r) begin
          // report the set and start a fresh one
          out_valid_nxt = 1'b1;
          out_min_nxt   = min_r;
          out_ovf_nxt   = ovf_now;
          count_nxt     = '0;
          min_nxt       = mpsd_pkg::NO_PAIR_SCORE;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
        state_nxt = mpsd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpsd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      row_r       <= '0;
      drain_r     <= '0;
      min_r       <= mpsd_pkg::NO_PAIR_SCORE;
      ovf_r       <= 1'b0;
      vld_d1_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      row_r       <= row_nxt;
      drain_r     <= drain_nxt;
      min_r       <= min_nxt;
      ovf_r       <= ovf_nxt;
      vld_d1_r    <= vld_d1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    point_r   <= point_nxt;
    last_r    <= last_nxt;
    out_min_r <= out_min_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign busy                = (state_r != mpsd_pkg::ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_min_sq_distance = out_min_r;
  assign out_overflow        = out_ovf_r;

  // the minimum never climbs above the no-pair score
  `MPSD_ASSERT(a_min_bound, clk, rst_n, out_valid |-> (out_min_sq_distance <= mpsd_pkg::NO_PAIR_SCORE), "result above no-pair score")
  // an accepted transaction keeps the unit busy on the next cycle
  `MPSD_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accepted point did not raise busy")
  // row results only arrive while a scan or its drain is running
  `MPSD_ASSERT(a_merge_window, clk, rst_n, mrg_res.valid |-> ((state_r == mpsd_pkg::ST_SCAN) || (state_r == mpsd_pkg::ST_DRAIN)), "row result outside scan")
  // a result strobe lasts one cycle and follows the finish step
  `MPSD_ASSERT(a_strobe_single, clk, rst_n, out_valid |-> (!$past(out_valid) && ($past(state_r) == mpsd_pkg::ST_FINISH)), "stray result strobe")
  // fill count stays within the store once reset has been applied
  `MPSD_ASSERT_ALWAYS(a_count_bound, clk, rst_n |-> (count_r <= mpsd_pkg::CNT_W'(mpsd_pkg::MAX_POINTS)), "fill count past store depth")

endmodule

`default_nettype wire
